>>> rtl/pdt_pkg.sv
// shared types and constants for the periodic down timer
package pdt_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int DATA_WIDTH      = 32;

    // command codes carried in the top bits of the request
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    // register map
    typedef enum logic [2:0] {
        REG_LOAD    = 3'd0,
        REG_VALUE   = 3'd1,
        REG_CTRL    = 3'd2,
        REG_IRQCLR  = 3'd3,
        REG_RAWIRQ  = 3'd4,
        REG_MASKIRQ = 3'd5,
        REG_RELOAD  = 3'd6,
        REG_FREECNT = 3'd7
    } reg_idx_t;

    // control register bit positions
    localparam int CTRL_FREERUN_BIT = 9;
    localparam int CTRL_DEBUG_BIT   = 8;
    localparam int CTRL_ENABLE_BIT  = 7;
    localparam int CTRL_IRQEN_BIT   = 5;
    localparam int CTRL_PRE_LO_BIT  = 2;
    localparam int CTRL_23BIT_BIT   = 1;

    // prescale select codes
    localparam logic [1:0] PRE_DIV1   = 2'd0;
    localparam logic [1:0] PRE_DIV16  = 2'd1;
    localparam logic [1:0] PRE_DIV256 = 2'd2;
    // spare code, behaves as divide by one
    localparam logic [1:0] PRE_ALT_DIV1 = 2'd3;

    localparam logic [7:0] PRE_DIV16_M1  = 8'd15;
    localparam logic [7:0] PRE_DIV256_M1 = 8'd255;

    typedef struct packed {
        logic [1:0]            command;
        logic [2:0]            reg_index;
        logic [DATA_WIDTH-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  access_error;
        logic                  irq_out;
    } rsp_t;

endpackage

>>> rtl/pdt_core.sv
// timer register file, prescaler and counters with the per-word response logic
module pdt_core import pdt_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic req_valid,
    input  req_t req,
    output rsp_t rsp
);

    logic [COUNT_WIDTH-1:0] reload_reg, reload_next;
    logic [COUNT_WIDTH-1:0] down_reg, down_next;
    logic [COUNT_WIDTH-1:0] free_reg, free_next;
    logic                   pend_reg, pend_next;
    logic                   freerun_reg, freerun_next;
    logic                   debug_reg, debug_next;
    logic                   enable_reg, enable_next;
    logic                   irqen_reg, irqen_next;
    logic                   b23_reg, b23_next;
    logic [1:0]             presel_reg, presel_next;
    logic [7:0]             precnt_reg, precnt_next;

    logic [7:0]             div_m1;
    logic [COUNT_WIDTH-1:0] dec_val;
    logic [1:0]             pre_code;
    logic [DATA_WIDTH-1:0]  ctrl_rd;
    cmd_t                   cmd;
    reg_idx_t               idx;

    assign cmd = cmd_t'(req.command);
    assign idx = reg_idx_t'(req.reg_index);

    always_comb begin
        case (presel_reg)
            PRE_DIV16:  div_m1 = PRE_DIV16_M1;
            PRE_DIV256: div_m1 = PRE_DIV256_M1;
            default:    div_m1 = 8'd0;
        endcase
    end

    assign dec_val  = down_reg - COUNT_WIDTH'(1);
    assign pre_code = (presel_reg == PRE_ALT_DIV1) ? PRE_DIV1 : presel_reg;

    always_comb begin
        ctrl_rd = '0;
        ctrl_rd[CTRL_FREERUN_BIT]                  = freerun_reg;
        ctrl_rd[CTRL_DEBUG_BIT]                    = debug_reg;
        ctrl_rd[CTRL_ENABLE_BIT]                   = enable_reg;
        ctrl_rd[CTRL_IRQEN_BIT]                    = irqen_reg;
        ctrl_rd[CTRL_PRE_LO_BIT+1:CTRL_PRE_LO_BIT] = pre_code;
        ctrl_rd[CTRL_23BIT_BIT]                    = b23_reg;
    end

    always_comb begin
        reload_next  = reload_reg;
        down_next    = down_reg;
        free_next    = free_reg;
        pend_next    = pend_reg;
        freerun_next = freerun_reg;
        debug_next   = debug_reg;
        enable_next  = enable_reg;
        irqen_next   = irqen_reg;
        b23_next     = b23_reg;
        presel_next  = presel_reg;
        precnt_next  = precnt_reg;
        rsp.read_data    = '0;
        rsp.access_error = 1'b0;

        case (cmd)
            CMD_READ: begin
                case (idx)
                    REG_LOAD:    rsp.read_data = DATA_WIDTH'(reload_reg);
                    REG_VALUE:   rsp.read_data = DATA_WIDTH'(down_reg);
                    REG_CTRL:    rsp.read_data = ctrl_rd;
                    REG_IRQCLR:  rsp.access_error = 1'b1;
                    REG_RAWIRQ:  rsp.read_data = DATA_WIDTH'(pend_reg);
                    REG_MASKIRQ: rsp.read_data = DATA_WIDTH'(pend_reg & irqen_reg);
                    REG_RELOAD:  rsp.read_data = DATA_WIDTH'(reload_reg);
                    REG_FREECNT: rsp.read_data = DATA_WIDTH'(free_reg);
                    default:     rsp.read_data = '0;
                endcase
            end
            CMD_WRITE: begin
                case (idx)
                    REG_LOAD: begin
                        reload_next = req.write_data[COUNT_WIDTH-1:0];
                        down_next   = req.write_data[COUNT_WIDTH-1:0];
                    end
                    REG_CTRL: begin
                        freerun_next = req.write_data[CTRL_FREERUN_BIT];
                        debug_next   = req.write_data[CTRL_DEBUG_BIT];
                        enable_next  = req.write_data[CTRL_ENABLE_BIT];
                        irqen_next   = req.write_data[CTRL_IRQEN_BIT];
                        b23_next     = req.write_data[CTRL_23BIT_BIT];
                        presel_next  = req.write_data[CTRL_PRE_LO_BIT+1:CTRL_PRE_LO_BIT];
                    end
                    REG_IRQCLR: pend_next   = 1'b0;
                    REG_RELOAD: reload_next = req.write_data[COUNT_WIDTH-1:0];
                    default:    rsp.access_error = 1'b1;
                endcase
            end
            CMD_TICK: begin
                if (enable_reg) begin
                    if (precnt_reg >= div_m1) begin
                        precnt_next = 8'd0;
                        // zero test follows the decrement, so zero wraps to all ones
                        if (dec_val == '0) begin
                            down_next = reload_reg;
                            free_next = '0;
                            pend_next = 1'b1;
                        end else begin
                            down_next = dec_val;
                            free_next = free_reg + COUNT_WIDTH'(1);
                        end
                    end else begin
                        precnt_next = precnt_reg + 8'd1;
                    end
                end
            end
            default: ;
        endcase

        rsp.irq_out = pend_next & irqen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg  <= '0;
            down_reg    <= '0;
            free_reg    <= '0;
            pend_reg    <= 1'b0;
            freerun_reg <= 1'b0;
            debug_reg   <= 1'b0;
            enable_reg  <= 1'b0;
            irqen_reg   <= 1'b0;
            b23_reg     <= 1'b0;
            presel_reg  <= PRE_DIV1;
            precnt_reg  <= 8'd0;
        end else if (req_valid) begin
            reload_reg  <= reload_next;
            down_reg    <= down_next;
            free_reg    <= free_next;
            pend_reg    <= pend_next;
            freerun_reg <= freerun_next;
            debug_reg   <= debug_next;
            enable_reg  <= enable_next;
            irqen_reg   <= irqen_next;
            b23_reg     <= b23_next;
            presel_reg  <= presel_next;
            precnt_reg  <= precnt_next;
        end
    end

endmodule

>>> rtl/periodic_down_timer_with_regs_top.sv
// Periodic down timer with a register interface, driven as a stream of words.
// Each input word is a bus read, a bus write or one base clock tick, and yields
// exactly one response word. One word is accepted per cycle; its response
// appears in the output register on the next cycle, and a new word is taken
// whenever that register is empty or being drained in the same cycle. Counter
// width is COUNT_WIDTH bits (16 to 32); reads return it zero-extended to 32.
module periodic_down_timer_with_regs_top import pdt_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // write_data
    input  logic [4:0]  s_tuser,   // command [1:0], reg_index [4:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data
    output logic [1:0]  m_tuser    // access_error [0], irq_out [1]
);

    logic accept;
    req_t req;
    rsp_t rsp;
    logic m_tvalid_reg;
    rsp_t rsp_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign req.command    = s_tuser[1:0];
    assign req.reg_index  = s_tuser[4:2];
    assign req.write_data = s_tdata;

    pdt_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (accept),
        .req       (req),
        .rsp       (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rsp_reg <= rsp;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = rsp_reg.read_data;
    assign m_tuser[0] = rsp_reg.access_error;
    assign m_tuser[1] = rsp_reg.irq_out;

endmodule
